// ----- src/crm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_pkg: shared types and constants of the counter rate monitor
// Register indexes, monitor states, event modes, reset values and divider types.
// ----------------------------------------------------------------------------
package crm_pkg;

	localparam int unsigned WINDOW_DEF = 8;

	typedef enum logic [2:0] {
		REG_MIN_GAP   = 3'd0,
		REG_MAX_GAP   = 3'd1,
		REG_MAX_RATE  = 3'd2,
		REG_EMA_ALPHA = 3'd3,
		REG_FAIL_HOLD = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_FAIL   = 2'd1,
		MODE_LOGOUT = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		MST_INIT   = 2'd0,
		MST_LOGGED = 2'd1,
		MST_ERROR  = 2'd2,
		MST_OUT    = 2'd3
	} mstate_t;

	localparam logic [31:0] MIN_GAP_RST   = 32'd500;
	localparam logic [31:0] MAX_GAP_RST   = 32'd10000;
	localparam logic [31:0] MAX_RATE_RST  = 32'hFFFF_FFFF;
	localparam logic [15:0] ALPHA_RST     = 16'd19661;
	localparam logic [7:0]  FAIL_HOLD_RST = 8'd3;
	localparam logic [17:0] KB_MS_SCALE   = 18'd256000;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

// ----- src/crm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_ram: generic single-port RAM with registered read
// One write and one read of the same address per cycle; the read returns the old word.
// ----------------------------------------------------------------------------
module crm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- src/crm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_div: shared restoring divider, one quotient bit per cycle
// 64-bit dividend by 32-bit divisor; done pulses after the last step.
// ----------------------------------------------------------------------------
module crm_div
	import crm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};

endmodule

// ----- src/counter_rate_monitor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_rate_monitor_core: windowed average and EMA transfer rate meter
// Steps: failure, logout and non-rate samples go from S_EVAL to S_OUT; a sample
//   that yields a rate runs two divisions on the shared divider (rate, then
//   window mean), ring access and, once the EMA is seeded, the EMA multiplies;
//   a zero gap skips the rate division.
// Throughput: one item at a time; ready is low while an item is in work.
// Reset: asynchronous, active low; registers to reset values, state init.
// ----------------------------------------------------------------------------
module counter_rate_monitor_core
	import crm_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF,
	localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
	localparam int unsigned FW = $clog2(WINDOW + 1),
	localparam int unsigned SW = 32 + FW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] time_ms,
	input  logic [39:0] count_kb,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  monitor_state,
	output logic [31:0] shown_rate,
	output logic        rate_ok,
	output logic [39:0] used_total,
	output logic        usage_known,
	output logic [7:0]  failures
);

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL, S_RDIV, S_RCHK, S_RDOLD, S_SUM, S_MDIV, S_MUL1, S_MUL2,
		S_EMA, S_OUT
	} fsm_t;

	fsm_t        st_q;
	logic [31:0] min_gap_q, max_gap_q, max_rate_q;
	logic [15:0] alpha_q;
	logic [7:0]  fail_hold_q;
	logic [1:0]  mode_q;
	logic [31:0] time_q;
	logic [39:0] cnt_q;

	logic [PW-1:0] pos_q;
	logic [FW-1:0] fill_q;
	logic [SW-1:0] sum_q;
	logic [31:0]   smooth_q;
	logic          seeded_q;
	logic [31:0]   prev_time_q;
	logic [39:0]   prev_cnt_q;
	logic          have_base_q, base_pend_q;
	mstate_t       mst_q;
	logic          rok_q, uknown_q;
	logic [7:0]    fail_q;
	logic [31:0]   shown_q;
	logic [39:0]   used_q;
	logic [31:0]   gap_q;
	logic [39:0]   delta_q;
	logic [31:0]   inst_q;
	logic [31:0]   mean_q;
	logic [47:0]   acc_q;

	div_req_t    dreq;
	div_rsp_t    drsp;
	logic        ram_we;
	logic [31:0] ram_rd;
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] mul_p;
	logic [32:0] gap_full;
	logic [57:0] dkb;
	logic        div_go_q;

	crm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	crm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
		.clk(clk), .we(ram_we), .addr(pos_q), .wdata(inst_q), .rdata(ram_rd)
	);

	assign in_ready  = (st_q == S_IDLE);
	assign gap_full  = {1'b0, time_q} - {1'b0, prev_time_q};
	assign dkb       = delta_q * KB_MS_SCALE;
	assign ram_we    = (st_q == S_SUM);
	assign mul_a     = (st_q == S_MUL1) ? mean_q : smooth_q;
	assign mul_b     = (st_q == S_MUL1) ? {1'b0, alpha_q} : (17'h10000 - {1'b0, alpha_q});
	assign mul_p     = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			min_gap_q   <= MIN_GAP_RST;
			max_gap_q   <= MAX_GAP_RST;
			max_rate_q  <= MAX_RATE_RST;
			alpha_q     <= ALPHA_RST;
			fail_hold_q <= FAIL_HOLD_RST;
			pos_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			smooth_q    <= '0;
			seeded_q    <= 1'b0;
			prev_time_q <= '0;
			prev_cnt_q  <= '0;
			have_base_q <= 1'b0;
			base_pend_q <= 1'b0;
			mst_q       <= MST_INIT;
			rok_q       <= 1'b0;
			uknown_q    <= 1'b0;
			fail_q      <= '0;
			shown_q     <= '0;
			used_q      <= '0;
			out_valid   <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_GAP:   min_gap_q   <= cfg_data;
					REG_MAX_GAP:   max_gap_q   <= cfg_data;
					REG_MAX_RATE:  max_rate_q  <= cfg_data;
					REG_EMA_ALPHA: alpha_q     <= cfg_data[15:0];
					REG_FAIL_HOLD: fail_hold_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						time_q <= time_ms;
						cnt_q  <= count_kb;
						st_q   <= S_EVAL;
					end
				end
				S_EVAL: begin
					st_q <= S_OUT;
					case (mode_q)
						MODE_SAMPLE: begin
							fail_q <= '0;
							if (cnt_q == '0 && uknown_q && used_q != '0) begin
								mst_q <= MST_LOGGED;
							end else begin
								used_q   <= cnt_q;
								uknown_q <= 1'b1;
								mst_q    <= MST_LOGGED;
								if (!have_base_q || base_pend_q) begin
									prev_time_q <= time_q;
									prev_cnt_q  <= cnt_q;
									have_base_q <= 1'b1;
									base_pend_q <= 1'b0;
								end else if (gap_full[32] || gap_full[31:0] < min_gap_q) begin
									st_q <= S_OUT;
								end else if (gap_full[31:0] > max_gap_q || cnt_q < prev_cnt_q) begin
									prev_time_q <= time_q;
									prev_cnt_q  <= cnt_q;
									rok_q       <= 1'b0;
								end else begin
									prev_time_q <= time_q;
									prev_cnt_q  <= cnt_q;
									gap_q       <= gap_full[31:0];
									delta_q     <= cnt_q - prev_cnt_q;
									if (gap_full[31:0] == '0) begin
										if (cnt_q != prev_cnt_q) begin
											shown_q <= '0;
											rok_q   <= 1'b1;
										end else begin
											inst_q <= '0;
											st_q   <= S_RDOLD;
										end
									end else begin
										div_go_q <= 1'b1;
										st_q     <= S_RDIV;
									end
								end
							end
						end
						MODE_FAIL: begin
							if (fail_q != 8'hFF) begin
								fail_q <= fail_q + 8'd1;
							end
							if (((fail_q != 8'hFF) ? fail_q + 8'd1 : fail_q) > fail_hold_q) begin
								mst_q <= MST_ERROR;
								rok_q <= 1'b0;
							end else if (mst_q == MST_INIT) begin
								mst_q <= MST_ERROR;
							end
							base_pend_q <= 1'b1;
							have_base_q <= 1'b0;
						end
						MODE_LOGOUT: begin
							fail_q      <= '0;
							mst_q       <= MST_OUT;
							rok_q       <= 1'b0;
							uknown_q    <= 1'b0;
							base_pend_q <= 1'b1;
							have_base_q <= 1'b0;
						end
						default: ;
					endcase
				end
				S_RDIV: begin
					if (drsp.done) begin
						st_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					if (drsp.quotient > {32'd0, max_rate_q}) begin
						shown_q <= '0;
						rok_q   <= 1'b1;
						st_q    <= S_OUT;
					end else begin
						inst_q <= drsp.quotient[31:0];
						st_q   <= S_RDOLD;
					end
				end
				S_RDOLD: begin
					st_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= sum_q - SW'(ram_rd & {32{fill_q == FW'(WINDOW)}}) + SW'(inst_q);
					if (fill_q != FW'(WINDOW)) begin
						fill_q <= fill_q + FW'(1);
					end
					pos_q <= (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + PW'(1);
					st_q  <= S_MDIV;
				end
				S_MDIV: begin
					if (drsp.done) begin
						mean_q <= drsp.quotient[31:0];
						if (!seeded_q) begin
							smooth_q <= drsp.quotient[31:0];
							shown_q  <= drsp.quotient[31:0];
							seeded_q <= 1'b1;
							rok_q    <= 1'b1;
							st_q     <= S_OUT;
						end else begin
							st_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					acc_q <= mul_p[47:0];
					st_q  <= S_MUL2;
				end
				S_MUL2: begin
					acc_q <= acc_q + mul_p[47:0] + 48'd32768;
					st_q  <= S_EMA;
				end
				S_EMA: begin
					smooth_q <= acc_q[47:16];
					shown_q  <= acc_q[47:16];
					rok_q    <= 1'b1;
					st_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = {6'd0, dkb};
		dreq.divisor  = gap_q;
		if (div_go_q) begin
			dreq.start = 1'b1;
		end else if (st_q == S_SUM) begin
			dreq.start    = 1'b1;
			dreq.dividend = 64'(sum_q - SW'(ram_rd & {32{fill_q == FW'(WINDOW)}})
			                + SW'(inst_q));
			dreq.divisor  = 32'((fill_q == FW'(WINDOW)) ? fill_q : fill_q + FW'(1));
		end
	end

	assign monitor_state = mst_q;
	assign shown_rate    = shown_q;
	assign rate_ok       = rok_q;
	assign used_total    = used_q;
	assign usage_known   = uknown_q;
	assign failures      = fail_q;

endmodule

// ----- src/crm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_checker: port-level checks of the counter rate monitor
// Bound to the top level.
// ----------------------------------------------------------------------------
module crm_checker
	import crm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] monitor_state,
	input logic       usage_known
);

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while item pending");

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("item dropped");

	ap_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after take");

	ap_logout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && monitor_state == MST_OUT |-> !usage_known)
		else $error("usage known while logged out");

endmodule

bind counter_rate_monitor_core crm_checker u_crm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.monitor_state(monitor_state), .usage_known(usage_known)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the counter rate monitor
// Drives sample, failure and logout items through the valid/ready input,
// predicts each snapshot with a cycle-free model of the rate window and EMA,
// and compares every snapshot field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
	import crm_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam int WDOG_LIMIT = 20000;
	localparam logic [2:0] REG_BAD = 3'd7;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] rate;
		logic        ok;
		logic [39:0] used;
		logic        known;
		logic [7:0]  fails;
	} snap_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [31:0] time_ms = '0;
	logic [39:0] count_kb = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  monitor_state;
	logic [31:0] shown_rate;
	logic        rate_ok;
	logic [39:0] used_total;
	logic        usage_known;
	logic [7:0]  failures;

	counter_rate_monitor_core i_dut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [31:0] p_min_gap, p_max_gap, p_max_rate, p_fail_hold;
	logic [15:0] p_alpha;
	logic [31:0] p_ring [WIN];
	int unsigned p_pos, p_fill;
	longint unsigned p_sum;
	logic [31:0] p_ema;
	bit          p_seeded, p_have_base, p_base_pend;
	logic [31:0] p_prev_t;
	logic [39:0] p_prev_c;
	snap_t       p_snap;

	snap_t       snap_q [$];
	int          n_err = 0;
	int          n_snaps = 0;
	int          n_items = 0;
	bit          idle_in = 1'b1;
	bit          idle_out = 1'b1;
	int          hold_cmd = 0;
	int          hold_seen = 0;
	int          hold_off = 0;
	logic [31:0] t_now;
	logic [39:0] c_now;

	task automatic predictor_reset();
		p_min_gap = MIN_GAP_RST;
		p_max_gap = MAX_GAP_RST;
		p_max_rate = MAX_RATE_RST;
		p_alpha = ALPHA_RST;
		p_fail_hold = FAIL_HOLD_RST;
		p_pos = 0;
		p_fill = 0;
		p_sum = 0;
		p_ema = 0;
		p_seeded = 0;
		p_have_base = 0;
		p_base_pend = 0;
		p_prev_t = 0;
		p_prev_c = 0;
		p_snap = '{MST_INIT, 32'd0, 1'b0, 40'd0, 1'b0, 8'd0};
	endtask

	task automatic window_push(logic [31:0] r);
		longint unsigned mean, acc;
		if (p_fill >= WIN)
			p_sum -= p_ring[p_pos];
		else
			p_fill++;
		p_ring[p_pos] = r;
		p_sum += r;
		p_pos = (p_pos + 1) % WIN;
		mean = p_sum / p_fill;
		if (!p_seeded) begin
			p_ema = mean[31:0];
			p_seeded = 1;
		end else begin
			acc = longint'(p_alpha) * mean + (65536 - longint'(p_alpha)) * p_ema + 32768;
			p_ema = acc[47:16];
		end
		p_snap.rate = p_ema;
		p_snap.ok = 1'b1;
	endtask

	task automatic predict_sample(logic [31:0] t, logic [39:0] c);
		logic [31:0] gap;
		logic [39:0] delta;
		logic [127:0] inst;
		bit over;
		p_snap.fails = 0;
		if (c == 0 && p_snap.known && p_snap.used != 0) begin
			p_snap.st = MST_LOGGED;
			return;
		end
		p_snap.used = c;
		p_snap.known = 1'b1;
		p_snap.st = MST_LOGGED;
		if (!p_have_base || p_base_pend) begin
			p_prev_t = t;
			p_prev_c = c;
			p_have_base = 1;
			p_base_pend = 0;
			return;
		end
		if (t < p_prev_t) return;
		gap = t - p_prev_t;
		if (gap < p_min_gap) return;
		if (gap > p_max_gap || c < p_prev_c) begin
			p_prev_t = t;
			p_prev_c = c;
			p_snap.ok = 1'b0;
			return;
		end
		delta = c - p_prev_c;
		p_prev_t = t;
		p_prev_c = c;
		if (gap == 0) begin
			over = (delta != 0);
			inst = 0;
		end else begin
			inst = ({88'd0, delta} * 128'd256000) / gap;
			inst = inst & 128'hFFFF_FFFF_FFFF_FFFF;
			over = inst > p_max_rate;
		end
		if (over) begin
			p_snap.rate = 0;
			p_snap.ok = 1'b1;
			return;
		end
		window_push(inst[31:0]);
	endtask

	task automatic predict_event(logic [1:0] m, logic [31:0] t, logic [39:0] c);
		case (m)
			MODE_SAMPLE: predict_sample(t, c);
			MODE_FAIL: begin
				if (p_snap.fails != 8'd255) p_snap.fails++;
				if (p_snap.fails > p_fail_hold) begin
					p_snap.st = MST_ERROR;
					p_snap.ok = 1'b0;
				end else if (p_snap.st == MST_INIT) begin
					p_snap.st = MST_ERROR;
				end
				p_base_pend = 1;
				p_have_base = 0;
			end
			MODE_LOGOUT: begin
				p_snap.fails = 0;
				p_snap.st = MST_OUT;
				p_snap.ok = 1'b0;
				p_snap.known = 1'b0;
				p_base_pend = 1;
				p_have_base = 0;
			end
			default: ;
		endcase
		snap_q.push_back(p_snap);
	endtask

	task automatic send_item(logic [1:0] m, logic [31:0] t, logic [39:0] c);
		if (!idle_in && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		time_ms <= t;
		count_kb <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_event(m, t, c);
		n_items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (snap_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_GAP: p_min_gap = v;
			REG_MAX_GAP: p_max_gap = v;
			REG_MAX_RATE: p_max_rate = v;
			REG_EMA_ALPHA: p_alpha = v[15:0];
			REG_FAIL_HOLD: p_fail_hold = {24'd0, v[7:0]};
			default: ;
		endcase
	endtask

	task automatic write_bad_index();
		cfg_we <= 1'b1;
		cfg_index <= REG_BAD;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// advance time and counter by random steps, mostly well formed
	task automatic send_step(int gap_hi, int kb_hi);
		t_now = t_now + $urandom_range(0, gap_hi);
		c_now = c_now + $urandom_range(0, kb_hi);
		send_item(MODE_SAMPLE, t_now, c_now);
	endtask

	task automatic test_directed();
		t_now = 1000;
		c_now = 40'd100;
		send_item(MODE_SAMPLE, t_now, c_now);
		send_item(MODE_SAMPLE, t_now + 1000, c_now + 50);
		send_item(MODE_SAMPLE, t_now + 1100, c_now + 60);
		send_item(MODE_SAMPLE, t_now + 2000, 40'd0);
		send_item(MODE_SAMPLE, t_now + 500, c_now + 10);
		send_item(MODE_SAMPLE, t_now + 3000, c_now + 5);
		send_item(MODE_SAMPLE, t_now + 20000, c_now + 900);
		send_item(MODE_SAMPLE, t_now + 21000, 40'hFF_FFFF_FFFF);
		send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_item(MODE_RSVD, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_item(MODE_FAIL, 0, 0);
		send_item(MODE_SAMPLE, 32'd0, 40'd0);
		send_item(MODE_SAMPLE, 32'd600, 40'd0);
		repeat (5) send_item(MODE_FAIL, 0, 0);
		send_item(MODE_LOGOUT, 0, 0);
		send_item(MODE_SAMPLE, 32'd100, 40'd0);
		send_item(MODE_SAMPLE, 32'd700, 40'd0);
		send_item(MODE_SAMPLE, 32'd9000, 40'd5);
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(REG_MIN_GAP, 32'd0);
		write_reg(REG_MAX_GAP, 32'hFFFF_FFFF);
		write_reg(REG_MAX_RATE, 32'd1000);
		write_reg(REG_EMA_ALPHA, 32'hFFFF);
		write_reg(REG_FAIL_HOLD, 32'd0);
		write_bad_index();
		send_item(MODE_LOGOUT, 0, 0);
		send_item(MODE_SAMPLE, 32'd10, 40'd10);
		send_item(MODE_SAMPLE, 32'd10, 40'd10);
		send_item(MODE_SAMPLE, 32'd10, 40'd11);
		send_item(MODE_SAMPLE, 32'd20, 40'd11);
		send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_item(MODE_FAIL, 0, 0);
		drain();
		write_reg(REG_MAX_RATE, 32'hFFFF_FFFF);
		write_reg(REG_EMA_ALPHA, 32'd0);
		write_reg(REG_FAIL_HOLD, 32'd255);
		t_now = 0;
		c_now = 0;
		send_item(MODE_LOGOUT, 0, 0);
		repeat (300) send_item(MODE_FAIL, 0, 0);
		repeat (12) send_step(4000, 100000);
		drain();
	endtask

	task automatic random_phase(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 80)
				send_step(3000, 1 << $urandom_range(0, 30));
			else if (k < 86)
				send_item(MODE_FAIL, $urandom, 40'({$urandom, $urandom}));
			else if (k < 89)
				send_item(MODE_LOGOUT, $urandom, 40'({$urandom, $urandom}));
			else if (k < 91)
				send_item(MODE_RSVD, $urandom, 40'({$urandom, $urandom}));
			else if (k < 94)
				send_item(MODE_SAMPLE, t_now + $urandom_range(0, 20000), 40'd0);
			else begin
				t_now = $urandom;
				c_now = 40'({$urandom, $urandom});
				send_item(MODE_SAMPLE, t_now, c_now);
			end
		end
		drain();
	endtask

	task automatic test_random();
		logic [31:0] v;
		for (int ph = 0; ph < 6; ph++) begin
			v = $urandom_range(0, 1500);
			write_reg(REG_MIN_GAP, v);
			write_reg(REG_MAX_GAP, v + $urandom_range(0, 4000));
			write_reg(REG_MAX_RATE, (ph % 2) ? $urandom : 32'hFFFF_FFFF);
			write_reg(REG_EMA_ALPHA, $urandom_range(0, 65535));
			write_reg(REG_FAIL_HOLD, $urandom_range(0, 6));
			random_phase(80);
		end
	endtask

	task automatic test_backpressure();
		hold_cmd++;
		repeat (30) send_step(2000, 5000);
		drain();
		idle_in = 1'b1;
		idle_out = 1'b1;
		repeat (60) send_step(2000, 5000);
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_cmd != hold_seen) begin
			hold_seen <= hold_cmd;
			hold_off <= 300;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (!idle_out && $urandom_range(0, 4) == 0) begin
			hold_off <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		snap_t e;
		if (out_valid && out_ready) begin
			n_snaps++;
			if (snap_q.size() == 0) begin
				$error("snapshot with nothing expected");
				n_err++;
			end else begin
				e = snap_q.pop_front();
				if (monitor_state !== e.st) begin
					$error("monitor_state exp %0d got %0d", e.st, monitor_state);
					n_err++;
				end
				if (shown_rate !== e.rate) begin
					$error("shown_rate exp %0d got %0d", e.rate, shown_rate);
					n_err++;
				end
				if (rate_ok !== e.ok) begin
					$error("rate_ok exp %0d got %0d", e.ok, rate_ok);
					n_err++;
				end
				if (used_total !== e.used) begin
					$error("used_total exp %0d got %0d", e.used, used_total);
					n_err++;
				end
				if (usage_known !== e.known) begin
					$error("usage_known exp %0d got %0d", e.known, usage_known);
					n_err++;
				end
				if (failures !== e.fails) begin
					$error("failures exp %0d got %0d", e.fails, failures);
					n_err++;
				end
			end
		end
	end

	int wdog = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		predictor_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_in = 1'b0;
		idle_out = 1'b0;
		test_config_extremes();
		test_random();
		test_backpressure();
		$display("covered %0d items, %0d snapshots checked, %0d mismatches",
			n_items, n_snaps, n_err);
		$display("register extremes, failures, logouts, window wrap and stalls exercised");
		if (n_err == 0 && snap_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
